@@ rtl/core/pcfm_pkg.sv @@
package pcfm_pkg;

   // Stream and control port widths
   localparam int REQ_W      = 48;  // plant_output 24 + reference 16 + clear 1, byte padded
   localparam int RSP_W      = 40;  // duty 16 + measurement 16 + polarity 1 + integrated 1
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;

   // Fixed point constants
   localparam logic [15:0] ONE_Q15  = 16'd32768;
   localparam logic [15:0] HALF_Q15 = 16'd16384;

   // Register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      REG_PROP_GAIN      = 3'd0,
      REG_INT_GAIN       = 3'd1,
      REG_FILTER_COEFF   = 3'd2,
      REG_INV_FULL_SCALE = 3'd3,
      REG_SIGNED_MEASURE = 3'd4
   } reg_index_type;

   // Multiplier operand pair
   typedef enum logic [1:0] {
      MUL_NORM,
      MUL_FILT,
      MUL_PROP,
      MUL_INTEG
   } mul_sel_type;

   // Datapath operation of one step
   typedef enum logic [2:0] {
      OP_NONE,
      OP_LOAD,
      OP_NORM,
      OP_FILT,
      OP_PROP,
      OP_INTEG,
      OP_FINISH
   } dp_op_type;

   // Sequencing of the step counter
   typedef enum logic [1:0] {
      SEQ_NEXT,
      SEQ_WAIT_REQ,
      SEQ_WAIT_RSP
   } seq_type;

   typedef struct packed {
      mul_sel_type mul_sel;
      logic        mul_en;
      dp_op_type   op;
      seq_type     seq;
   } ucode_type;

   // Qualified control toward the datapath
   typedef struct packed {
      mul_sel_type mul_sel;
      logic        mul_en;
      dp_op_type   op;
   } ctrl_type;

   localparam int STEP_W = 3;

   function automatic ucode_type ucode_rom(input logic [STEP_W-1:0] step);
      ucode_type w;
      unique case (step)
         3'd0: w = '{MUL_NORM,  1'b1, OP_LOAD,   SEQ_WAIT_REQ};
         3'd1: w = '{MUL_NORM,  1'b0, OP_NORM,   SEQ_NEXT};
         3'd2: w = '{MUL_FILT,  1'b1, OP_NONE,   SEQ_NEXT};
         3'd3: w = '{MUL_FILT,  1'b0, OP_FILT,   SEQ_NEXT};
         3'd4: w = '{MUL_PROP,  1'b1, OP_NONE,   SEQ_NEXT};
         3'd5: w = '{MUL_INTEG, 1'b1, OP_PROP,   SEQ_NEXT};
         3'd6: w = '{MUL_INTEG, 1'b0, OP_INTEG,  SEQ_NEXT};
         3'd7: w = '{MUL_INTEG, 1'b0, OP_FINISH, SEQ_WAIT_RSP};
         default: w = '{MUL_NORM, 1'b0, OP_NONE, SEQ_NEXT};
      endcase
      return w;
   endfunction

endpackage

@@ rtl/core/pcfm_sequencer.sv @@
module pcfm_sequencer (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_avail,   // request waiting
   input  logic                rsp_free,    // output register can take a result
   output logic                idle,
   output pcfm_pkg::ctrl_type  ctrl
);
   import pcfm_pkg::*;

   logic [STEP_W-1:0] step_ff, step_in;
   ucode_type         word;
   logic              go;

   assign word = ucode_rom(step_ff);

   always_comb begin
      unique case (word.seq)
         SEQ_WAIT_REQ: go = req_avail;
         SEQ_WAIT_RSP: go = rsp_free;
         SEQ_NEXT:     go = 1'b1;
         default:      go = 1'b0;
      endcase
   end

   // next step
   always_comb begin
      step_in = step_ff;
      if (go) begin
         step_in = step_ff + STEP_W'(1);  // last step wraps to the idle step
      end
   end

   // outputs
   always_comb begin
      idle         = (word.seq == SEQ_WAIT_REQ);
      ctrl.mul_sel = word.mul_sel;
      ctrl.mul_en  = word.mul_en & go;
      ctrl.op      = go ? word.op : OP_NONE;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
      end else begin
         step_ff <= step_in;
      end
   end

endmodule

@@ rtl/core/pi_controller_with_filtered_measure_core.sv @@
// A request runs through the eight-step microprogram, which shares one multiplier; the result is
// registered at the finish step once the output register is free. A new request is taken only after the last step.
// The next request is taken while a finished result still waits in the output register.
// Reset (synchronous, active high): integrator and filter cleared, registers at defaults,
// sequencer at its idle step, no result pending.
module pi_controller_with_filtered_measure_core (
   input  logic                                 clock,
   input  logic                                 reset,
   // request stream
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // [23:0] plant_output, [39:24] reference, [40] clear, [47:41] zero
   input  logic [pcfm_pkg::REQ_W-1:0]           req_tdata,
   // result stream
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // [15:0] duty, [31:16] measurement, [32] polarity, [33] integrated, [39:34] zero
   output logic [pcfm_pkg::RSP_W-1:0]           rsp_tdata,
   // register writes
   input  logic                                 csr_we,
   input  logic [pcfm_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [pcfm_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import pcfm_pkg::*;

   // ---------------------------------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------------------------------
   logic [15:0] kp_ff, kp_in;
   logic [15:0] ki_ff, ki_in;
   logic [15:0] alpha_ff, alpha_in;
   logic [23:0] inv_ff, inv_in;
   logic        signed_ff, signed_in;

   always_comb begin
      kp_in     = kp_ff;
      ki_in     = ki_ff;
      alpha_in  = alpha_ff;
      inv_in    = inv_ff;
      signed_in = signed_ff;
      if (csr_we) begin
         unique case (csr_index)
            REG_PROP_GAIN:      kp_in     = csr_wdata[15:0];
            REG_INT_GAIN:       ki_in     = csr_wdata[15:0];
            REG_FILTER_COEFF:   alpha_in  = csr_wdata[15:0];
            REG_INV_FULL_SCALE: inv_in    = csr_wdata;
            REG_SIGNED_MEASURE: signed_in = csr_wdata[0];
            default: ;  // unmapped index, write dropped
         endcase
      end
   end

   // ---------------------------------------------------------------------------------------
   // Sequencer: eight microcode steps, step 0 waits for a request, step 7 for the output slot
   // ---------------------------------------------------------------------------------------
   ctrl_type ctrl;
   logic     rsp_valid_ff, rsp_valid_in;
   logic     rsp_free;
   logic     seq_idle;

   assign rsp_free = ~rsp_valid_ff | rsp_tready;

   pcfm_sequencer u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_avail (req_tvalid),
      .rsp_free  (rsp_free),
      .idle      (seq_idle),
      .ctrl      (ctrl)
   );

   assign req_tready = seq_idle;

   // ---------------------------------------------------------------------------------------
   // Request fields
   // ---------------------------------------------------------------------------------------
   logic signed [23:0] req_y;
   logic        [15:0] req_ref;
   logic               req_clr;

   assign req_y   = req_tdata[23:0];
   assign req_ref = req_tdata[39:24];
   assign req_clr = req_tdata[40];

   // ---------------------------------------------------------------------------------------
   // Shared multiplier, 25 x 25 signed, registered product
   // ---------------------------------------------------------------------------------------
   logic signed [24:0] mul_a, mul_b;
   logic signed [49:0] prod_ff, prod_in;

   // working registers
   logic        [15:0] ref_ff, ref_in;     // reference saturated to 1.0
   logic signed [16:0] diff_ff, diff_in;   // m - f, Q15
   logic signed [16:0] err_ff, err_in;     // ref - f, Q15
   logic signed [23:0] up_ff, up_in;       // proportional term, Q18
   logic signed [23:0] ui_ff, ui_in;       // proposed integrator, Q18
   // state
   logic signed [23:0] integ_ff, integ_in; // Q18
   logic        [15:0] filt_ff, filt_in;   // Q15, 0..1
   // output register
   logic [RSP_W-1:0]   rsp_data_ff, rsp_data_in;

   always_comb begin
      unique case (ctrl.mul_sel)
         MUL_NORM:  begin mul_a = {req_y[23], req_y};        mul_b = {1'b0, inv_ff};   end
         MUL_FILT:  begin mul_a = {{8{diff_ff[16]}}, diff_ff}; mul_b = {9'd0, alpha_ff}; end
         MUL_PROP:  begin mul_a = {{8{err_ff[16]}}, err_ff};   mul_b = {9'd0, kp_ff};    end
         MUL_INTEG: begin mul_a = {{8{err_ff[16]}}, err_ff};   mul_b = {9'd0, ki_ff};    end
         default:   begin mul_a = '0;                          mul_b = '0;              end
      endcase
      prod_in = ctrl.mul_en ? mul_a * mul_b : prod_ff;
   end

   // ---------------------------------------------------------------------------------------
   // Normalization: signed maps to 0.5 + 0.5y (floor), magnitude maps |y| (floor), clamp to 1.0
   // ---------------------------------------------------------------------------------------
   logic signed [32:0] norm_sgn;
   logic signed [49:0] prod_neg;
   logic        [48:0] prod_mag;
   logic        [32:0] norm_mag;
   logic        [15:0] norm_m;

   always_comb begin
      norm_sgn = $signed(prod_ff[49:17]) + 33'sd16384;
      prod_neg = -prod_ff;
      prod_mag = prod_ff[49] ? prod_neg[48:0] : prod_ff[48:0];
      norm_mag = prod_mag[48:16];
      if (signed_ff) begin
         if (norm_sgn < 33'sd0) begin
            norm_m = 16'd0;
         end else if (norm_sgn > 33'sd32768) begin
            norm_m = ONE_Q15;
         end else begin
            norm_m = norm_sgn[15:0];
         end
      end else begin
         norm_m = (norm_mag > 33'd32768) ? ONE_Q15 : norm_mag[15:0];
      end
   end

   // ---------------------------------------------------------------------------------------
   // Filter update, rounded, clamped to 0..1
   // ---------------------------------------------------------------------------------------
   logic signed [49:0] filt_rnd;
   logic signed [17:0] filt_sum;
   logic        [15:0] filt_new;

   always_comb begin
      filt_rnd = prod_ff + 50'sd32768;
      filt_sum = $signed({2'b00, filt_ff}) + $signed(filt_rnd[33:16]);
      if (filt_sum < 18'sd0) begin
         filt_new = 16'd0;
      end else if (filt_sum > 18'sd32768) begin
         filt_new = ONE_Q15;
      end else begin
         filt_new = filt_sum[15:0];
      end
   end

   // ---------------------------------------------------------------------------------------
   // PI terms: rounded products, integrator proposal saturated to 24 bits
   // ---------------------------------------------------------------------------------------
   logic signed [49:0] p_rnd, i_rnd;
   logic signed [25:0] ui_sum;
   logic signed [23:0] ui_sat;

   always_comb begin
      p_rnd  = prod_ff + 50'sd256;
      i_rnd  = prod_ff + 50'sd4096;
      ui_sum = {{2{integ_ff[23]}}, integ_ff} + {{6{i_rnd[32]}}, i_rnd[32:13]};
      if (ui_sum > 26'sd8388607) begin
         ui_sat = 24'sh7FFFFF;
      end else if (ui_sum < -26'sd8388608) begin
         ui_sat = 24'sh800000;
      end else begin
         ui_sat = ui_sum[23:0];
      end
   end

   // ---------------------------------------------------------------------------------------
   // Conditional integration and duty
   // ---------------------------------------------------------------------------------------
   logic signed [24:0] u_try, u_keep, u_sel;
   logic               err_neg, err_pos, take;
   logic        [18:0] u_clamp;
   logic        [19:0] u_rnd;
   logic        [15:0] duty;
   logic               polarity;

   always_comb begin
      u_try   = {up_ff[23], up_ff} + {ui_ff[23], ui_ff};
      u_keep  = {up_ff[23], up_ff} + {integ_ff[23], integ_ff};
      err_neg = err_ff[16];
      err_pos = ~err_ff[16] & (err_ff != 17'sd0);
      // inside the range, or the error pulls back from a limit
      take    = ((u_try > 25'sd0) && (u_try < 25'sd262144))
              || ((u_try >= 25'sd262144) && err_neg)
              || ((u_try <= 25'sd0) && err_pos);
      u_sel   = take ? u_try : u_keep;
      if (u_sel < 25'sd0) begin
         u_clamp = 19'd0;
      end else if (u_sel > 25'sd262144) begin
         u_clamp = 19'd262144;
      end else begin
         u_clamp = u_sel[18:0];
      end
      u_rnd    = {1'b0, u_clamp} + 20'd4;
      duty     = u_rnd[18:3];
      polarity = (ref_ff >= HALF_Q15);
   end

   // ---------------------------------------------------------------------------------------
   // Datapath register updates per microcode operation
   // ---------------------------------------------------------------------------------------
   always_comb begin
      ref_in      = ref_ff;
      diff_in     = diff_ff;
      err_in      = err_ff;
      up_in       = up_ff;
      ui_in       = ui_ff;
      integ_in    = integ_ff;
      filt_in     = filt_ff;
      rsp_data_in = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      unique case (ctrl.op)
         OP_LOAD: begin
            ref_in = (req_ref > ONE_Q15) ? ONE_Q15 : req_ref;
            if (req_clr) begin
               integ_in = '0;
               filt_in  = '0;
            end
         end
         OP_NORM: begin
            diff_in = $signed({1'b0, norm_m}) - $signed({1'b0, filt_ff});
         end
         OP_FILT: begin
            filt_in = filt_new;
            err_in  = $signed({1'b0, ref_ff}) - $signed({1'b0, filt_new});
         end
         OP_PROP: begin
            up_in = p_rnd[32:9];
         end
         OP_INTEG: begin
            ui_in = ui_sat;
         end
         OP_FINISH: begin
            if (take) begin
               integ_in = ui_ff;
            end
            rsp_data_in  = {6'd0, take, polarity, filt_ff, duty};
            rsp_valid_in = 1'b1;
         end
         OP_NONE: ;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kp_ff        <= 16'd2048;
         ki_ff        <= 16'd1966;
         alpha_ff     <= 16'd1311;
         inv_ff       <= 24'd65536;
         signed_ff    <= 1'b0;
         integ_ff     <= '0;
         filt_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         kp_ff        <= kp_in;
         ki_ff        <= ki_in;
         alpha_ff     <= alpha_in;
         inv_ff       <= inv_in;
         signed_ff    <= signed_in;
         integ_ff     <= integ_in;
         filt_ff      <= filt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff     <= prod_in;
      ref_ff      <= ref_in;
      diff_ff     <= diff_in;
      err_ff      <= err_in;
      up_ff       <= up_in;
      ui_ff       <= ui_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef SYNTH
   // sequencer leaves the idle step once a request is taken
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request accepted but sequencer still idle");

   // final step always lands a result in the output register
   a_finish_emits: assert property (@(posedge clock) disable iff (reset)
      (ctrl.op == OP_FINISH) |=> rsp_valid_ff)
      else $error("finish step produced no result");

   // filter state is within 0..1 after each filter update
   a_filter_range: assert property (@(posedge clock) disable iff (reset)
      ctrl.op == OP_FILT |=> filt_ff <= ONE_Q15)
      else $error("filter state out of range");

   // duty stays within 0..1 while presented
   a_duty_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_data_ff[15:0] <= ONE_Q15)
      else $error("duty out of range");
`endif

endmodule
